>>> rtl/smam_pkg.sv
// ----------------------------------------------------------------------------
// smam_pkg
// shared types and constants for the square matrix add and multiply block
// ----------------------------------------------------------------------------
package smam_pkg;

    localparam int WORD_W      = 32;
    localparam int IDX_W       = 4;
    localparam int DIM_W       = 5;
    localparam int OP_W        = 2;
    localparam int PADDR_W     = 2;
    localparam int PDATA_W     = 32;
    localparam int MAX_DIM_DEF = 16;

    localparam logic [DIM_W-1:0]   DIM_RESET = 5'd16;
    localparam logic [PADDR_W-1:0] ADDR_DIM  = 2'd0;

    localparam logic [OP_W-1:0] OP_LOAD_A = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_B = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic clr;
        logic sum_en;
        logic mul_en;
    } t_mac_ctl;

    typedef struct packed {
        logic             load;
        logic             err;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } t_res;

endpackage

>>> rtl/smam_ram.sv
// ----------------------------------------------------------------------------
// smam_ram
// one-write one-read synchronous memory, registered read data
// ----------------------------------------------------------------------------
module smam_ram
    import smam_pkg::*;
#(
    parameter int DEPTH = MAX_DIM_DEF * MAX_DIM_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [WORD_W-1:0] i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output logic [WORD_W-1:0] o_rdata
);

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/smam_mac.sv
// ----------------------------------------------------------------------------
// smam_mac
// element adder and single multiply-accumulate over streamed element pairs
// ----------------------------------------------------------------------------
module smam_mac
    import smam_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_mac_ctl          i_ctl,
    input  logic [WORD_W-1:0] i_a,
    input  logic [WORD_W-1:0] i_b,
    output logic [WORD_W-1:0] o_sum,
    output logic [WORD_W-1:0] o_acc,
    output logic              o_busy
);

    logic [WORD_W-1:0] r_prod;
    logic              r_prod_vld;
    logic [WORD_W-1:0] r_sum;
    logic [WORD_W-1:0] r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_ctl.mul_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= i_a * i_b;
        end
        if (i_ctl.sum_en) begin
            r_sum <= i_a + i_b;
        end
        if (i_ctl.clr) begin
            r_acc <= '0;
        end else if (r_prod_vld) begin
            r_acc <= r_acc + r_prod;
        end
    end

    assign o_sum  = r_sum;
    assign o_acc  = r_acc;
    assign o_busy = r_prod_vld;

endmodule

>>> rtl/smam_ctrl.sv
// ----------------------------------------------------------------------------
// smam_ctrl
// sequencer: store writes, sum read, dot product address walk, result hand-off
// ----------------------------------------------------------------------------
module smam_ctrl
    import smam_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF,
    parameter int AW      = (MAX_DIM * MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [DIM_W-1:0]  i_dim,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [OP_W-1:0]   i_operation,
    input  logic [IDX_W-1:0]  i_row,
    input  logic [IDX_W-1:0]  i_col,
    output logic              o_we_a,
    output logic              o_we_b,
    output logic [AW-1:0]     o_waddr,
    output logic [AW-1:0]     o_raddr_a,
    output logic [AW-1:0]     o_raddr_b,
    output t_mac_ctl          o_mac_ctl,
    input  logic              i_mac_busy,
    input  logic              i_slot_free,
    output t_res              o_res
);

    localparam int NW_MIN = $clog2(MAX_DIM + 1);
    localparam int NW     = (NW_MIN > DIM_W) ? NW_MIN : DIM_W;
    localparam int IW     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam logic [NW-1:0] MAXN = NW'(MAX_DIM);
    localparam logic [AW-1:0] STRIDE = AW'(MAX_DIM);

    t_state           r_state, n_state;
    logic [IW-1:0]    r_k, n_k;
    logic [IDX_W-1:0] r_row, r_col;
    logic             r_err;
    logic             r_iss_vld;
    logic             r_sum_cap;

    logic [NW-1:0] dim_ext;
    logic [NW-1:0] live_n;
    logic          in_range;
    logic          accept;
    logic          rd_go;
    logic          last_k;
    logic [AW-1:0] port_addr;

    assign dim_ext   = NW'(i_dim);
    assign live_n    = (dim_ext > MAXN) ? MAXN : dim_ext;
    assign in_range  = (NW'(i_row) < live_n) && (NW'(i_col) < live_n);
    assign accept    = i_in_valid && !o_in_stall;
    assign rd_go     = accept && (i_operation == OP_READ);
    assign last_k    = (NW'(r_k) == (live_n - NW'(1)));
    assign port_addr = AW'(AW'(i_row) * STRIDE + AW'(i_col));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_iss_vld <= 1'b0;
            r_sum_cap <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_iss_vld <= (r_state == ST_ISSUE);
            r_sum_cap <= rd_go && in_range;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k <= n_k;
        if (rd_go) begin
            r_row <= i_row;
            r_col <= i_col;
            r_err <= !in_range;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_k        = r_k;
        o_in_stall = 1'b1;
        o_we_a     = 1'b0;
        o_we_b     = 1'b0;
        o_waddr    = port_addr;
        o_raddr_a  = port_addr;
        o_raddr_b  = port_addr;
        o_mac_ctl.clr    = 1'b0;
        o_mac_ctl.sum_en = r_sum_cap;
        o_mac_ctl.mul_en = r_iss_vld;
        o_res.load = 1'b0;
        o_res.err  = r_err;
        o_res.row  = r_row;
        o_res.col  = r_col;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                n_k        = '0;
                if (accept) begin
                    case (i_operation)
                        OP_LOAD_A: o_we_a = in_range;
                        OP_LOAD_B: o_we_b = in_range;
                        OP_READ: begin
                            o_mac_ctl.clr = 1'b1;
                            n_state = in_range ? ST_ISSUE : ST_DRAIN;
                        end
                        default: ;
                    endcase
                end
            end
            ST_ISSUE: begin
                o_raddr_a = AW'(AW'(r_row) * STRIDE + AW'(r_k));
                o_raddr_b = AW'(AW'(r_k) * STRIDE + AW'(r_col));
                n_k       = r_k + IW'(1);
                if (last_k) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!r_iss_vld && !i_mac_busy && i_slot_free) begin
                    o_res.load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

>>> rtl/square_matrix_add_multiply.sv
// ----------------------------------------------------------------------------
// square_matrix_add_multiply
// two square integer matrices in memory, element sum and product element read
// ----------------------------------------------------------------------------
// load word: accepted back to back
// read word in range: n A/B element pairs are multiply-accumulated; the input stalls
//   until the result is loaded; n = min(dim, MAX_DIM), one element pair per cycle
// read word out of range: the input stalls until the flagged result is loaded
// a result stalled in the output register holds back the next read's result
// reset: synchronous, active low; dim returns to 16, matrix memories are not cleared
module square_matrix_add_multiply
    import smam_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [PADDR_W-1:0]       paddr,
    input  logic [PDATA_W-1:0]       pwdata,
    output logic [PDATA_W-1:0]       prdata,
    output logic                     pready,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [OP_W-1:0]          i_operation,
    input  logic [IDX_W-1:0]         i_row,
    input  logic [IDX_W-1:0]         i_col,
    input  logic signed [WORD_W-1:0] i_value,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [IDX_W-1:0]         o_out_row,
    output logic [IDX_W-1:0]         o_out_col,
    output logic signed [WORD_W-1:0] o_sum_value,
    output logic signed [WORD_W-1:0] o_prod_value,
    output logic                     o_index_error
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [DIM_W-1:0]  r_dim;
    logic              r_out_valid;
    logic [IDX_W-1:0]  r_out_row, r_out_col;
    logic [WORD_W-1:0] r_out_sum, r_out_prod;
    logic              r_out_err;

    logic              we_a, we_b;
    logic [AW-1:0]     waddr, raddr_a, raddr_b;
    logic [WORD_W-1:0] rdata_a, rdata_b;
    t_mac_ctl          mac_ctl;
    logic [WORD_W-1:0] mac_sum, mac_acc;
    logic              mac_busy;
    logic              slot_free;
    t_res              res;

    // register port
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_DIM) ? PDATA_W'(r_dim) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim <= DIM_RESET;
        end else if (psel && penable && pwrite && pready && (paddr == ADDR_DIM)) begin
            r_dim <= pwdata[DIM_W-1:0];
        end
    end

    smam_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (waddr),
        .i_wdata (i_value),
        .i_raddr (raddr_a),
        .o_rdata (rdata_a)
    );

    smam_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (waddr),
        .i_wdata (i_value),
        .i_raddr (raddr_b),
        .o_rdata (rdata_b)
    );

    smam_ctrl #(.MAX_DIM(MAX_DIM), .AW(AW)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_dim       (r_dim),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_operation (i_operation),
        .i_row       (i_row),
        .i_col       (i_col),
        .o_we_a      (we_a),
        .o_we_b      (we_b),
        .o_waddr     (waddr),
        .o_raddr_a   (raddr_a),
        .o_raddr_b   (raddr_b),
        .o_mac_ctl   (mac_ctl),
        .i_mac_busy  (mac_busy),
        .i_slot_free (slot_free),
        .o_res       (res)
    );

    smam_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_a     (rdata_a),
        .i_b     (rdata_b),
        .o_sum   (mac_sum),
        .o_acc   (mac_acc),
        .o_busy  (mac_busy)
    );

    // result register
    assign slot_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res.load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.load) begin
            r_out_row  <= res.row;
            r_out_col  <= res.col;
            r_out_err  <= res.err;
            r_out_sum  <= res.err ? '0 : mac_sum;
            r_out_prod <= res.err ? '0 : mac_acc;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_row     = r_out_row;
    assign o_out_col     = r_out_col;
    assign o_sum_value   = r_out_sum;
    assign o_prod_value  = r_out_prod;
    assign o_index_error = r_out_err;

endmodule

>>> rtl/smam_checker.sv
// ----------------------------------------------------------------------------
// smam_checker
// port-level checks for square_matrix_add_multiply, attached by bind
// ----------------------------------------------------------------------------
module smam_checker
    import smam_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     o_in_stall,
    input logic [OP_W-1:0]          i_operation,
    input logic                     o_out_valid,
    input logic                     i_out_stall,
    input logic [IDX_W-1:0]         o_out_row,
    input logic [IDX_W-1:0]         o_out_col,
    input logic signed [WORD_W-1:0] o_sum_value,
    input logic signed [WORD_W-1:0] o_prod_value,
    input logic                     o_index_error
);

    logic in_acc;
    assign in_acc = i_in_valid && !o_in_stall;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_sum_value)
            && $stable(o_prod_value) && $stable(o_out_row) && $stable(o_out_col))
        else $error("result word changed while stalled");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_index_error |-> (o_sum_value == 0) && (o_prod_value == 0))
        else $error("flagged result carries non-zero values");

    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_operation == OP_READ) |=> o_in_stall)
        else $error("input taken while a read is in progress");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_operation != OP_READ) |=> !o_in_stall)
        else $error("input stalled after a load word");

endmodule

bind square_matrix_add_multiply smam_checker u_smam_checker (.*);
